[rtl/core/spq_pkg.sv]
// package of shared types and constants for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DATA_W       = 32;
    localparam int OCC_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 128;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

    // contents of one cell as seen by its neighbors
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] rank;
    } t_slot;

    // command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cmd;

endpackage

[rtl/core/spq_cell.sv]
// one storage cell of the sorted priority queue chain
`timescale 1ns / 1ps

module spq_cell #(
    parameter bit HEAD = 1'b0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spq_pkg::t_cmd                    i_cmd,
    input  logic signed [spq_pkg::DATA_W-1:0] i_new_value,
    input  logic signed [spq_pkg::DATA_W-1:0] i_new_rank,
    input  spq_pkg::t_slot                   i_prev_slot,
    input  logic                             i_prev_place,
    input  spq_pkg::t_slot                   i_next_slot,
    output spq_pkg::t_slot                   o_slot,
    output logic                             o_place
);

    logic                             r_vld;
    logic signed [spq_pkg::DATA_W-1:0] r_value;
    logic signed [spq_pkg::DATA_W-1:0] r_rank;
    logic                             n_vld;
    logic signed [spq_pkg::DATA_W-1:0] n_value;
    logic signed [spq_pkg::DATA_W-1:0] n_rank;
    logic                             w_ge;
    logic                             take_new;
    logic                             take_prev;

    // head cell keeps an entry of equal rank in front of the new one
    assign w_ge    = HEAD ? (r_rank > i_new_rank) : (r_rank >= i_new_rank);
    assign o_place = !r_vld || w_ge;

    assign take_new  = i_cmd.ins && o_place && !i_prev_place;
    assign take_prev = i_cmd.ins && o_place && i_prev_place;

    always_comb begin
        n_vld   = r_vld;
        n_value = r_value;
        n_rank  = r_rank;
        if (i_cmd.rem) begin
            n_vld   = i_next_slot.vld;
            n_value = i_next_slot.value;
            n_rank  = i_next_slot.rank;
        end else if (take_new) begin
            n_vld   = 1'b1;
            n_value = i_new_value;
            n_rank  = i_new_rank;
        end else if (take_prev) begin
            n_vld   = i_prev_slot.vld;
            n_value = i_prev_slot.value;
            n_rank  = i_prev_slot.rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_rank  <= n_rank;
    end

    assign o_slot = '{vld: r_vld, value: r_value, rank: r_rank};

endmodule

[rtl/core/sorted_priority_queue_core.sv]
// top level of the sorted priority queue built as a chain of compare-and-shift cells
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_op, i_item_value, i_item_rank
// result    out        o_valid / i_stall    o_status, o_out_value, o_out_rank,
//                                           o_occupancy, o_empty_flag, o_full_flag
//
// one transfer per cycle while o_stall is low: every cell compares its rank
// with the new rank in parallel and shifts in one step, so an item finishes in
// the cycle it is taken, and its result is held in an output register
// reset clears the cell valid bits and the count at once, no clearing pass
// input stalls only while a finished result is held and the output is stalled

module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_op,
    input  logic signed [spq_pkg::DATA_W-1:0]  i_item_value,
    input  logic signed [spq_pkg::DATA_W-1:0]  i_item_rank,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [spq_pkg::STATUS_W-1:0]       o_status,
    output logic signed [spq_pkg::DATA_W-1:0]  o_out_value,
    output logic signed [spq_pkg::DATA_W-1:0]  o_out_rank,
    output logic [spq_pkg::OCC_W-1:0]          o_occupancy,
    output logic                               o_empty_flag,
    output logic                               o_full_flag
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // chain wiring
    spq_pkg::t_slot slot_q [CAPACITY];
    logic           place  [CAPACITY];
    spq_pkg::t_cmd  cmd;

    // occupancy and result register
    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;
    logic                              r_out_valid;
    logic [spq_pkg::STATUS_W-1:0]      r_status;
    logic [spq_pkg::STATUS_W-1:0]      n_status;
    logic signed [spq_pkg::DATA_W-1:0] r_out_value;
    logic signed [spq_pkg::DATA_W-1:0] r_out_rank;
    logic [CNT_W-1:0]                  r_occ;

    logic accept;
    logic is_full;
    logic is_empty;

    // input held only when the result register is full and cannot drain
    assign o_stall  = r_out_valid && i_stall;
    assign accept   = i_valid && !o_stall;
    assign is_full  = (r_count == CNT_FULL);
    assign is_empty = (r_count == '0);

    // inserts on a full queue and removes on an empty one leave the cells alone
    assign cmd.ins = accept && (i_op == spq_pkg::OP_INSERT) && !is_full;
    assign cmd.rem = accept && (i_op == spq_pkg::OP_REMOVE) && !is_empty;

    // row of cells, head at index zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_slot prev_slot;
        spq_pkg::t_slot next_slot;
        logic           prev_place;

        if (g == 0) begin : g_head
            assign prev_slot  = '0;
            assign prev_place = 1'b0;
        end else begin : g_body
            assign prev_slot  = slot_q[g-1];
            assign prev_place = place[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_slot = '0;
        end else begin : g_link
            assign next_slot = slot_q[g+1];
        end

        spq_cell #(
            .HEAD (g == 0)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_new_value  (i_item_value),
            .i_new_rank   (i_item_rank),
            .i_prev_slot  (prev_slot),
            .i_prev_place (prev_place),
            .i_next_slot  (next_slot),
            .o_slot       (slot_q[g]),
            .o_place      (place[g])
        );
    end

    // status and count after this step
    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_INSERTED;
        if (i_op == spq_pkg::OP_INSERT) begin
            if (is_full) begin
                n_status = spq_pkg::ST_DROPPED;
            end else begin
                n_status = spq_pkg::ST_INSERTED;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (is_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_status = spq_pkg::ST_REMOVED;
                n_count  = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, front entry reported only on a real remove
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_occ       <= n_count;
            r_out_value <= cmd.rem ? slot_q[0].value : '0;
            r_out_rank  <= cmd.rem ? slot_q[0].rank  : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_out_value  = r_out_value;
    assign o_out_rank   = r_out_rank;
    assign o_occupancy  = spq_pkg::OCC_W'(r_occ);
    assign o_empty_flag = (r_occ == '0);
    assign o_full_flag  = (r_occ == CNT_FULL);

endmodule

[tb/sorted_priority_queue_core_tb.sv]
// self-checking testbench for the sorted priority queue core
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;

    localparam int QCAP       = spq_pkg::CAPACITY_DEF;
    localparam int CLK_HALF   = 5;
    localparam int DRAIN_WAIT = 20000;

    typedef struct packed {
        logic [spq_pkg::STATUS_W-1:0]      status;
        logic signed [spq_pkg::DATA_W-1:0] value;
        logic signed [spq_pkg::DATA_W-1:0] rank;
        logic [spq_pkg::OCC_W-1:0]         occ;
        logic                              empty;
        logic                              full;
    } t_spq_outcome;

    logic                               i_clk        = 1'b0;
    logic                               i_rst_n      = 1'b0;
    logic                               i_valid      = 1'b0;
    logic                               i_op         = spq_pkg::OP_INSERT;
    logic signed [spq_pkg::DATA_W-1:0]  i_item_value = '0;
    logic signed [spq_pkg::DATA_W-1:0]  i_item_rank  = '0;
    logic                               i_stall      = 1'b0;
    logic                               o_stall;
    logic                               o_valid;
    logic [spq_pkg::STATUS_W-1:0]       o_status;
    logic signed [spq_pkg::DATA_W-1:0]  o_out_value;
    logic signed [spq_pkg::DATA_W-1:0]  o_out_rank;
    logic [spq_pkg::OCC_W-1:0]          o_occupancy;
    logic                               o_empty_flag;
    logic                               o_full_flag;

    // mirror of the stored entries, kept in service order
    logic signed [spq_pkg::DATA_W-1:0]  held_value [QCAP];
    logic signed [spq_pkg::DATA_W-1:0]  held_rank  [QCAP];
    int                                 held_count = 0;

    t_spq_outcome              pending_outcomes [$];
    int                        err_count  = 0;
    int                        idle_pct   = 0;
    int                        stall_pct  = 0;
    int                        hold_req   = 0;
    int                        hold_done  = 0;
    int                        hold_left  = 0;

    sorted_priority_queue_core #(
        .CAPACITY (QCAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_item_value (i_item_value),
        .i_item_rank  (i_item_rank),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_out_value  (o_out_value),
        .o_out_rank   (o_out_rank),
        .o_occupancy  (o_occupancy),
        .o_empty_flag (o_empty_flag),
        .o_full_flag  (o_full_flag)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // applies one operation to the mirror and returns the outcome it must produce
    function automatic t_spq_outcome predict_step(
        input logic op,
        input logic signed [spq_pkg::DATA_W-1:0] value,
        input logic signed [spq_pkg::DATA_W-1:0] rank);
        t_spq_outcome res;
        int           pos;
        int           i;
        res = '0;
        if (op == spq_pkg::OP_INSERT) begin
            if (held_count >= QCAP) begin
                res.status = spq_pkg::ST_DROPPED;
            end else begin
                pos = 0;
                // an equal rank at the front lands right behind it
                if (held_count > 0 && held_rank[0] == rank) begin
                    pos = 1;
                end else begin
                    for (i = 0; i < held_count; i++) begin
                        if (held_rank[i] < rank) pos++;
                    end
                end
                for (i = held_count; i > pos; i--) begin
                    held_value[i] = held_value[i-1];
                    held_rank[i]  = held_rank[i-1];
                end
                held_value[pos] = value;
                held_rank[pos]  = rank;
                held_count++;
                res.status = spq_pkg::ST_INSERTED;
            end
        end else begin
            if (held_count == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.value = held_value[0];
                res.rank  = held_rank[0];
                for (i = 1; i < held_count; i++) begin
                    held_value[i-1] = held_value[i];
                    held_rank[i-1]  = held_rank[i];
                end
                held_count--;
                res.status = spq_pkg::ST_REMOVED;
            end
        end
        res.occ   = spq_pkg::OCC_W'(held_count);
        res.empty = (held_count == 0);
        res.full  = (held_count >= QCAP);
        return res;
    endfunction

    // offers one item, with an optional idle gap first, and waits for its transfer
    task automatic send_item(input logic op,
                             input logic signed [spq_pkg::DATA_W-1:0] value,
                             input logic signed [spq_pkg::DATA_W-1:0] rank);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_item_value <= value;
        i_item_rank  <= rank;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_outcomes.push_back(predict_step(op, value, rank));
    endtask

    // receiver side: random stall, or a long counted hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_left = hold_req - 1;
            hold_done = hold_req;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_spq_outcome want;
        t_spq_outcome got;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            got = {o_status, o_out_value, o_out_rank, o_occupancy, o_empty_flag, o_full_flag};
            if (pending_outcomes.size() == 0) begin
                note_error($sformatf("result with nothing expected: status %0d value %0d rank %0d",
                                     got.status, got.value, got.rank));
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    note_error($sformatf({"mismatch: exp st %0d val %0d rank %0d occ %0d e %0b f %0b",
                                          " | got st %0d val %0d rank %0d occ %0d e %0b f %0b"},
                                         want.status, want.value, want.rank, want.occ,
                                         want.empty, want.full,
                                         got.status, got.value, got.rank, got.occ,
                                         got.empty, got.full));
                end
            end
        end
    end

    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_rank();
        logic signed [spq_pkg::DATA_W-1:0] r;
        case ($urandom_range(9))
            0, 1, 2: r = $signed($urandom_range(8)) - 4;
            3, 4, 5: r = $urandom;
            6:       r = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            7, 8:    r = (held_count > 0) ? held_rank[0] : $urandom;
            default: r = (held_count > 0) ? held_rank[$urandom_range(held_count - 1)] : $urandom;
        endcase
        return r;
    endfunction

    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
        logic signed [spq_pkg::DATA_W-1:0] v;
        case ($urandom_range(15))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2:       v = '0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_extremes();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(spq_pkg::OP_REMOVE, 32'sd0, 32'sd0);
        send_item(spq_pkg::OP_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_item(spq_pkg::OP_INSERT, 32'sh8000_0000, 32'sh8000_0000);
        send_item(spq_pkg::OP_INSERT, 32'sd0, 32'sd0);
        send_item(spq_pkg::OP_INSERT, -32'sd1, -32'sd1);
        repeat (4) send_item(spq_pkg::OP_REMOVE, 32'sh5a5a_5a5a, 32'sh0f0f_0f0f);
        send_item(spq_pkg::OP_REMOVE, 32'sd0, 32'sd0);
    endtask

    task automatic test_equal_ranks();
        idle_pct  = 25;
        stall_pct = 25;
        send_item(spq_pkg::OP_INSERT, 32'sd1, 32'sd5);
        // front exception: same rank as the front goes behind it
        send_item(spq_pkg::OP_INSERT, 32'sd2, 32'sd5);
        send_item(spq_pkg::OP_INSERT, 32'sd3, 32'sd5);
        send_item(spq_pkg::OP_INSERT, 32'sd4, 32'sd7);
        // equal rank not at the front goes ahead of the stored ones
        send_item(spq_pkg::OP_INSERT, 32'sd5, 32'sd7);
        send_item(spq_pkg::OP_INSERT, 32'sd6, 32'sd3);
        send_item(spq_pkg::OP_INSERT, 32'sd7, 32'sd5);
        repeat (8) send_item(spq_pkg::OP_REMOVE, 32'sd0, 32'sd0);
    endtask

    // long receiver hold-off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 300;
        repeat (20) send_item(spq_pkg::OP_INSERT, pick_value(), pick_rank());
        repeat (4) send_item(spq_pkg::OP_REMOVE, pick_value(), pick_rank());
    endtask

    // fill past capacity, mix, then drain past empty
    task automatic run_random_phase(input int send_idle, input int recv_stall);
        int seg;
        int n;
        int ins_pct;
        int j;
        logic op;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        for (seg = 0; seg < 3; seg++) begin
            case (seg)
                0:       begin n = 150; ins_pct = 95; end
                1:       begin n = $urandom_range(60, 20); ins_pct = 50; end
                default: begin n = 150; ins_pct = 5; end
            endcase
            for (j = 0; j < n; j++) begin
                op = ($urandom_range(99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
                send_item(op, pick_value(), pick_rank());
            end
        end
    endtask

    initial begin
        int waited;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_equal_ranks();
        test_output_backpressure();
        run_random_phase(0, 0);
        run_random_phase(75, 0);
        run_random_phase(0, 75);
        run_random_phase(25, 25);

        i_valid <= 1'b0;
        waited = 0;
        while (pending_outcomes.size() != 0 && waited < DRAIN_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_outcomes.size() != 0) begin
            note_error($sformatf("%0d expected results never arrived", pending_outcomes.size()));
        end
        repeat (5) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sorted_priority_queue_core.f]
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_tb.sv
